[hw/rtl/mmla_pkg.sv]
// ----------------------------------------------------------------------------
// mmla_pkg: shared types and constants
// Observation record, sequencer states and fixed-point constants for the
// methylation mixture log-likelihood accumulator.
// ----------------------------------------------------------------------------
package mmla_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 4;

  localparam logic [27:0] LN2_Q28   = 28'd186065279;
  localparam logic [40:0] RATIO_CAP = 41'h100_0000_0000;
  localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SUM_MIN = -48'sh8000_0000_0000;

  localparam logic REG_METH_FRACTION = 1'b0;
  localparam logic REG_FLAT_PRIOR    = 1'b1;

  typedef struct packed {
    logic        last_obs;
    logic [31:0] map_error;
    logic [31:0] meth_prob;
    logic [31:0] unmeth_prob;
  } obs_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MIX_A, ST_MIX_B, ST_MIX_C, ST_RES_A, ST_RES_B, ST_DIFF,
    ST_DIV_CHK, ST_DIV, ST_SQ0, ST_SQ1, ST_SQ2, ST_NORM, ST_LOGSQ,
    ST_LOGMUL, ST_LOGRND, ST_ACC
  } core_state_t;

  function automatic logic signed [47:0] sat_add(logic signed [47:0] a,
                                                 logic signed [48:0] b);
    logic signed [49:0] s;
    s = 50'(a) + 50'(b);
    if (s > 50'(SUM_MAX)) return SUM_MAX;
    if (s < 50'(SUM_MIN)) return SUM_MIN;
    return s[47:0];
  endfunction

endpackage

[hw/rtl/mmla_front.sv]
// ----------------------------------------------------------------------------
// mmla_front: input stage
// Accept observation items, unpack them into records and queue them for the
// arithmetic sequencer.
// ----------------------------------------------------------------------------
module mmla_front #(
  parameter int unsigned DEPTH = mmla_pkg::FIFO_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [95:0]   s_tdata,  // unmeth_prob, meth_prob, map_error
  input  logic          s_tlast,
  output mmla_pkg::obs_t obs,
  output logic          obs_valid,
  input  logic          obs_ready
);
  import mmla_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  obs_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;
  obs_t             in_obs;

  assign in_obs.unmeth_prob = s_tdata[31:0];
  assign in_obs.meth_prob   = s_tdata[63:32];
  assign in_obs.map_error   = s_tdata[95:64];
  assign in_obs.last_obs    = s_tlast;

  assign s_tready  = (count != CNT_W'(DEPTH));
  assign obs_valid = (count != '0);
  assign obs       = mem[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = obs_valid && obs_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_obs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

[hw/rtl/mmla_core.sv]
// ----------------------------------------------------------------------------
// mmla_core: arithmetic sequencer
// Form the mixture, divide, square and log one observation over many cycles
// (a zero mixture skips divide and log), then fold into the saturating sums.
// ----------------------------------------------------------------------------
module mmla_core (
  input  logic           clk,
  input  logic           rst,
  input  mmla_pkg::obs_t obs,
  input  logic           obs_valid,
  output logic           obs_ready,
  input  logic [31:0]    meth_fraction,
  input  logic [31:0]    flat_prior,
  output logic [47:0]    log_likelihood,
  output logic [47:0]    gradient,
  output logic [47:0]    curvature,
  output logic           res_valid,
  input  logic           res_ready
);
  import mmla_pkg::*;

  core_state_t state, state_next;

  obs_t               cur;
  logic [64:0]        acc65;
  logic [31:0]        mix;
  logic [63:0]        res;
  logic [63:0]        d;
  logic               neg;
  logic [63:0]        rem;
  logic [39:0]        q;
  logic [5:0]         cnt;
  logic [40:0]        r;
  logic [81:0]        sq;
  logic [63:0]        x;
  logic [5:0]         k;
  logic [31:0]        y;
  logic [27:0]        frac;
  logic [62:0]        lprod;
  logic signed [48:0] lterm;
  logic signed [47:0] loglik_sum;
  logic signed [47:0] grad_sum;
  logic signed [47:0] curv_sum;

  logic [32:0]        ome;
  logic [32:0]        omf;
  logic [31:0]        absdiff;
  logic               nbit;
  logic [64:0]        remsh;
  logic               qbit;
  logic [32:0]        y2;
  logic [34:0]        mag;
  logic [57:0]        sqv;
  logic [47:0]        sqc;
  logic signed [48:0] gterm;
  logic signed [48:0] cterm;
  logic signed [47:0] ll_new;
  logic signed [47:0] gr_new;
  logic signed [47:0] cv_new;
  logic               acc_go;
  logic               out_fire;

  assign ome     = 33'h1_0000_0000 - {1'b0, cur.map_error};
  assign omf     = 33'h1_0000_0000 - {1'b0, meth_fraction};
  assign absdiff = neg ? cur.unmeth_prob - cur.meth_prob : cur.meth_prob - cur.unmeth_prob;
  assign nbit    = (cnt >= 6'd24) ? d[4'(cnt - 6'd24)] : 1'b0;
  assign remsh   = {rem, nbit};
  assign qbit    = (remsh >= {1'b0, res});
  assign y2      = 33'(({32'd0, y} * {32'd0, y}) >> 31);
  assign mag     = ((35'(k) + 35'd1) << 28) - 35'(frac);
  assign sqv     = sq[81:24];
  assign sqc     = (sqv >= 58'h8000_0000_0000) ? 48'h8000_0000_0000 : sqv[47:0];
  assign gterm   = neg ? -49'(r) : 49'(r);
  assign cterm   = -49'({1'b0, sqc});
  assign ll_new  = sat_add(loglik_sum, lterm);
  assign gr_new  = sat_add(grad_sum, gterm);
  assign cv_new  = sat_add(curv_sum, cterm);
  assign out_fire = res_valid && res_ready;

  always_comb begin
    obs_ready = (state == ST_IDLE);
    acc_go    = (state == ST_ACC) && !(cur.last_obs && res_valid && !res_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (obs_valid) state_next = ST_MIX_A;
      ST_MIX_A:   state_next = ST_MIX_B;
      ST_MIX_B:   state_next = ST_MIX_C;
      ST_MIX_C:   state_next = ST_RES_A;
      ST_RES_A:   state_next = ST_RES_B;
      ST_RES_B:   state_next = ST_DIFF;
      ST_DIFF:    state_next = ST_DIV_CHK;
      ST_DIV_CHK: begin
        if (d == '0 || res == '0 || {16'd0, d} >= {res, 16'd0}) state_next = ST_SQ0;
        else state_next = ST_DIV;
      end
      ST_DIV:     if (cnt == '0) state_next = ST_SQ0;
      ST_SQ0:     state_next = ST_SQ1;
      ST_SQ1:     state_next = ST_SQ2;
      ST_SQ2:     state_next = (res == '0) ? ST_ACC : ST_NORM;
      ST_NORM:    if (x[63]) state_next = ST_LOGSQ;
      ST_LOGSQ:   if (cnt == '0) state_next = ST_LOGMUL;
      ST_LOGMUL:  state_next = ST_LOGRND;
      ST_LOGRND:  state_next = ST_ACC;
      ST_ACC:     if (acc_go) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE:  if (obs_valid) cur <= obs;
      ST_MIX_A: acc65 <= {32'd0, omf} * {33'd0, cur.unmeth_prob};
      ST_MIX_B: acc65 <= acc65 + 65'({32'd0, meth_fraction} * {32'd0, cur.meth_prob});
      ST_MIX_C: begin
        mix <= 32'((acc65 + 65'h8000_0000) >> 32);
        neg <= (cur.meth_prob < cur.unmeth_prob);
      end
      ST_RES_A: res <= {31'd0, ome} * {32'd0, mix};
      ST_RES_B: res <= res + ({32'd0, cur.map_error} * {32'd0, flat_prior});
      ST_DIFF:  d <= {31'd0, ome} * {32'd0, absdiff};
      ST_DIV_CHK: begin
        rem <= {16'd0, d[63:16]};
        q   <= '0;
        cnt <= 6'd39;
        if (d == '0) r <= '0;
        else r <= RATIO_CAP;
      end
      ST_DIV: begin
        rem <= qbit ? 64'(remsh - {1'b0, res}) : remsh[63:0];
        q   <= {q[38:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == '0) r <= {1'b0, q[38:0], qbit};
      end
      ST_SQ0: sq <= 82'({21'd0, r[19:0]} * {21'd0, r[19:0]});
      ST_SQ1: sq <= sq + (82'({20'd0, r[40:20]} * {21'd0, r[19:0]}) << 21);
      ST_SQ2: begin
        sq    <= sq + (82'({21'd0, r[40:20]} * {21'd0, r[40:20]}) << 40);
        x     <= res;
        k     <= '0;
        lterm <= 49'(SUM_MIN);
      end
      ST_NORM: begin
        if (x[63]) begin
          y    <= x[63:32];
          frac <= '0;
          cnt  <= 6'd27;
        end else begin
          x <= x << 1;
          k <= k + 1'b1;
        end
      end
      ST_LOGSQ: begin
        y    <= y2[32] ? y2[32:1] : y2[31:0];
        frac <= {frac[26:0], y2[32]};
        cnt  <= cnt - 1'b1;
      end
      ST_LOGMUL: lprod <= 63'({28'd0, mag} * {35'd0, LN2_Q28});
      ST_LOGRND: lterm <= -49'((lprod + 63'h8000_0000) >> 32);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loglik_sum <= '0;
      grad_sum   <= '0;
      curv_sum   <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (out_fire) res_valid <= 1'b0;
      if (acc_go) begin
        if (cur.last_obs) begin
          log_likelihood <= ll_new;
          gradient       <= gr_new;
          curvature      <= cv_new;
          res_valid      <= 1'b1;
          loglik_sum     <= '0;
          grad_sum       <= '0;
          curv_sum       <= '0;
        end else begin
          loglik_sum <= ll_new;
          grad_sum   <= gr_new;
          curv_sum   <= cv_new;
        end
      end
    end
  end

  a_div_rem_below: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < res))
    else $error("divider remainder not below divisor");

  a_log_norm: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOGSQ) |-> y[31])
    else $error("log operand left normal range");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (acc_go && cur.last_obs) |=> (loglik_sum == '0 && grad_sum == '0 && curv_sum == '0
                                  && res_valid))
    else $error("sums not cleared on last observation");

endmodule

[hw/rtl/methylation_mixture_loglik_accumulator_top.sv]
// ----------------------------------------------------------------------------
// methylation_mixture_loglik_accumulator_top: mixture log-likelihood sums
// Accumulate log-likelihood, gradient and curvature of a methylation
// fraction over a set of read observations.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one observation per item; tdata carries the unmethylated,
//   methylated and mapping-error probabilities (unsigned Q0.32), tlast marks
//   the last observation of a set.
//   Output stream m_*: one item per set, the three saturated Q24.24 sums.
//   APB port: meth_fraction at 0x0, flat_prior at 0x4; write while idle.
// Timing:
//   The sequencer takes one observation at a time. A zero mixture skips the
//   divider and the log; otherwise control and the multiplies are followed by
//   the serial divider (skipped when the ratio is zero or capped), the one-bit
//   normalizing shifter and the log squaring loop. The sums item appears
//   the cycle after the last observation finishes.
//   A short queue takes new items while the sequencer works.
// Reset clears the sums, the queue and the output valid flag; meth_fraction
// returns to 0 and flat_prior to 0.25. When m_tready is low the result holds
// and the sequencer waits at the end of the next last observation.
// ----------------------------------------------------------------------------
module methylation_mixture_loglik_accumulator_top #(
  parameter int unsigned FIFO_DEPTH = mmla_pkg::FIFO_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [95:0]   s_tdata,  // unmeth_prob, meth_prob, map_error
  input  logic          s_tlast,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [143:0]  m_tdata,  // log_likelihood, gradient, curvature
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import mmla_pkg::*;

  obs_t        obs;
  logic        obs_valid;
  logic        obs_ready;
  logic [31:0] meth_fraction;
  logic [31:0] flat_prior;
  logic [47:0] log_likelihood;
  logic [47:0] gradient;
  logic [47:0] curvature;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_FLAT_PRIOR) ? flat_prior : meth_fraction;

  always_ff @(posedge clk) begin
    if (rst) begin
      meth_fraction <= '0;
      flat_prior    <= 32'h4000_0000;
    end else if (wr_en) begin
      if (paddr[2] == REG_METH_FRACTION) meth_fraction <= pwdata;
      else flat_prior <= pwdata;
    end
  end

  mmla_front #(
    .DEPTH(FIFO_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .obs       (obs),
    .obs_valid (obs_valid),
    .obs_ready (obs_ready)
  );

  mmla_core u_core (
    .clk            (clk),
    .rst            (rst),
    .obs            (obs),
    .obs_valid      (obs_valid),
    .obs_ready      (obs_ready),
    .meth_fraction  (meth_fraction),
    .flat_prior     (flat_prior),
    .log_likelihood (log_likelihood),
    .gradient       (gradient),
    .curvature      (curvature),
    .res_valid      (m_tvalid),
    .res_ready      (m_tready)
  );

  assign m_tdata = {curvature, gradient, log_likelihood};

endmodule
